### design/gde_pkg.sv
// ----------------------------------------------------------------------------
// gde_pkg
// Shared types and constants for the gravity direction estimator.
// ----------------------------------------------------------------------------
package gde_pkg;

  // 9.80665 m/s^2 at 1/1024 m/s^2 per LSB
  localparam int unsigned GRAVITY_LSB = 10042;
  localparam int unsigned ALPHA_ONE   = 65536;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

  localparam int unsigned CFG_W     = 17;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BLEND_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAG_TOL     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP        = 2'd3;

  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned OUT_USER_W = 2;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SQ,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_GATE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_SEED,
    OP_BLEND_A,
    OP_BLEND_B,
    OP_BLEND_C,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] idx;    // axis select
    logic       phase;  // 0: raw sample, 1: blended vector
  } dp_cmd_t;

  typedef struct packed {
    logic sqrt_last;
    logic div_last;
    logic accept;
    logic seeded;
    logic root_zero;
    logic out_valid;
  } dp_sts_t;

endpackage

### design/gde_datapath.sv
// ----------------------------------------------------------------------------
// gde_datapath
// Shared multiplier, bit-serial square root and divider, vector state,
// counters, configuration registers and the result register.
// ----------------------------------------------------------------------------
module gde_datapath #(
  parameter int ACCEL_WIDTH    = 16,
  parameter int UNIT_FRAC_BITS = 14,
  parameter int IN_W           = 48
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gde_pkg::dp_cmd_t                    cmd,
  output gde_pkg::dp_sts_t                    sts,
  input  logic [IN_W-1:0]                     in_data,
  input  logic                                out_ready,
  output logic [gde_pkg::OUT_DATA_W-1:0]      out_data,
  output logic [gde_pkg::OUT_USER_W-1:0]      out_user,
  input  logic                                cfg_we,
  input  logic [gde_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gde_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int A    = ACCEL_WIDTH;
  localparam int F    = UNIT_FRAC_BITS;
  localparam int SH   = (F + 16 > 31) ? (F + 16 - 31) : 0;
  localparam int BMW  = F + 17 - SH;
  localparam int DVW  = (A > BMW) ? A : BMW;
  localparam int SQW  = 2 * DVW;
  localparam int RW   = DVW + 2;
  localparam int UW   = F + 2;
  localparam int QW   = F + 1;
  localparam int PW   = 17 + QW;
  localparam int SW   = PW + 1;
  localparam int MW   = (DVW > 17) ? DVW : 17;
  localparam int GW   = DVW + 16;
  localparam int SCW  = $clog2(DVW);
  localparam int DCW  = $clog2(QW);
  localparam logic [SW-1:0] HALF = (SH == 0) ? '0 : (SW'(1) << ((SH > 0) ? SH - 1 : 0));

  // configuration
  logic [16:0] blend_alpha_r;
  logic [15:0] warmup_r;
  logic [15:0] mag_tol_r;
  logic        flip_r;

  // sample and vector state
  logic [A-1:0]          a_mag_r [3];
  logic                  a_neg_r [3];
  logic signed [UW-1:0]  u_r     [3];
  logic signed [UW-1:0]  up_r    [3];
  logic [BMW-1:0]        b_mag_r [3];
  logic                  b_neg_r [3];
  logic [PW-1:0]         pa_r, pb_r;
  logic                  pa_neg_r, pb_neg_r;
  logic                  seeded_r, accept_r;
  logic [15:0]           acc_cnt_r, rej_cnt_r;
  logic [SQW-1:0]        sum_r;

  // square root
  logic [SQW-1:0] sv_r;
  logic [DVW-1:0] root_r;
  logic [RW-1:0]  srem_r;
  logic [SCW-1:0] scnt_r;

  // divider
  logic [QW-1:0]  dnum_r;
  logic [DVW-1:0] drem_r;
  logic [DVW-1:0] dd_r;
  logic [QW-1:0]  dq_r;
  logic [DCW-1:0] dcnt_r;
  logic           dneg_r;

  logic                            out_valid_r;
  logic [gde_pkg::OUT_DATA_W-1:0]  out_data_r;
  logic [gde_pkg::OUT_USER_W-1:0]  out_user_r;

  // ---- combinational helpers
  logic [A-1:0]          in_ax [3];
  logic [A-1:0]          in_mag [3];
  logic [MW-1:0]         mul_x, mul_y;
  logic [2*MW-1:0]       prod;
  logic [16:0]           alpha_sat, beta;
  logic [UW-1:0]         u_abs, up_abs;
  logic [RW-1:0]         s_cat, s_trial;
  logic                  s_ge;
  logic [DVW:0]          r_cat;
  logic                  d_ge;
  logic [DVW-1:0]        div_src;
  logic [DVW+QW-1:0]     div_num;
  logic [DVW-1:0]        dev;
  logic [29:0]           tol_g;
  logic                  gate_ok;
  logic signed [SW-1:0]  bl_a, bl_b, bl_sum;
  logic [SW-1:0]         bl_abs, bl_rnd;
  logic signed [UW-1:0]  q_signed;
  logic [15:0]           acc_cnt_nxt, rej_cnt_nxt;
  logic                  ready_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_ax[i]  = in_data[i*A +: A];
      in_mag[i] = in_ax[i][A-1] ? (~in_ax[i] + A'(1)) : in_ax[i];
    end
  end

  assign alpha_sat = (blend_alpha_r > 17'(gde_pkg::ALPHA_ONE)) ?
                     17'(gde_pkg::ALPHA_ONE) : blend_alpha_r;
  assign beta      = 17'(gde_pkg::ALPHA_ONE) - alpha_sat;
  assign u_abs     = u_r[cmd.idx][UW-1]  ? UW'(-u_r[cmd.idx])  : UW'(u_r[cmd.idx]);
  assign up_abs    = up_r[cmd.idx][UW-1] ? UW'(-up_r[cmd.idx]) : UW'(up_r[cmd.idx]);

  always_comb begin
    case (cmd.op)
      gde_pkg::OP_SQ: begin
        mul_x = cmd.phase ? MW'(b_mag_r[cmd.idx]) : MW'(a_mag_r[cmd.idx]);
        mul_y = mul_x;
      end
      gde_pkg::OP_BLEND_A: begin
        mul_x = MW'(alpha_sat);
        mul_y = MW'(u_abs[QW-1:0]);
      end
      gde_pkg::OP_BLEND_B: begin
        mul_x = MW'(beta);
        mul_y = MW'(up_abs[QW-1:0]);
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end
  assign prod = mul_x * mul_y;

  // one digit pair of the restoring square root
  assign s_cat   = {srem_r[RW-3:0], sv_r[SQW-1 -: 2]};
  assign s_trial = {root_r, 2'b01};
  assign s_ge    = (s_cat >= s_trial);

  // one bit of the restoring divider
  assign r_cat = {drem_r, dnum_r[QW-1]};
  assign d_ge  = (r_cat >= {1'b0, dd_r});

  // rounded quotient: (|v| << F) + d/2, high part goes to the remainder
  assign div_src = cmd.phase ? DVW'(b_mag_r[cmd.idx]) : DVW'(a_mag_r[cmd.idx]);
  assign div_num = ((DVW+QW)'(div_src) << F) + (DVW+QW)'(root_r >> 1);

  assign dev     = (root_r > DVW'(gde_pkg::GRAVITY_LSB)) ?
                   (root_r - DVW'(gde_pkg::GRAVITY_LSB)) :
                   (DVW'(gde_pkg::GRAVITY_LSB) - root_r);
  assign tol_g   = 30'(mag_tol_r) * 30'(gde_pkg::GRAVITY_LSB);
  assign gate_ok = (root_r != '0) && ({dev, 16'h0000} <= GW'(tol_g));

  assign bl_a   = pa_neg_r ? -$signed({1'b0, pa_r}) : $signed({1'b0, pa_r});
  assign bl_b   = pb_neg_r ? -$signed({1'b0, pb_r}) : $signed({1'b0, pb_r});
  assign bl_sum = bl_a + bl_b;
  assign bl_abs = bl_sum[SW-1] ? SW'(-bl_sum) : SW'(bl_sum);
  assign bl_rnd = (bl_abs + HALF) >> SH;

  assign q_signed = dneg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});

  assign acc_cnt_nxt = (accept_r && acc_cnt_r != gde_pkg::COUNT_MAX) ?
                       acc_cnt_r + 16'd1 : acc_cnt_r;
  assign rej_cnt_nxt = (!accept_r && rej_cnt_r != gde_pkg::COUNT_MAX) ?
                       rej_cnt_r + 16'd1 : rej_cnt_r;
  assign ready_nxt   = seeded_r && (acc_cnt_nxt >= warmup_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_alpha_r <= 17'd6554;
      warmup_r      <= 16'd10;
      mag_tol_r     <= 16'd9830;
      flip_r        <= 1'b0;
      seeded_r      <= 1'b0;
      accept_r      <= 1'b0;
      acc_cnt_r     <= '0;
      rej_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < 3; i++) up_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gde_pkg::REG_BLEND_ALPHA: blend_alpha_r <= cfg_wdata;
          gde_pkg::REG_WARMUP:      warmup_r      <= cfg_wdata[15:0];
          gde_pkg::REG_MAG_TOL:     mag_tol_r     <= cfg_wdata[15:0];
          gde_pkg::REG_FLIP:        flip_r        <= cfg_wdata[0];
          default: ;
        endcase
      end

      // a new result replaces one taken in the same cycle
      if (cmd.op == gde_pkg::OP_FINISH) out_valid_r <= 1'b1;
      else if (out_ready)               out_valid_r <= 1'b0;

      case (cmd.op)
        gde_pkg::OP_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            a_mag_r[i] <= in_mag[i];
            a_neg_r[i] <= in_ax[i][A-1];
          end
        end
        gde_pkg::OP_SQ: begin
          sum_r <= (cmd.idx == 2'd0) ? SQW'(prod) : sum_r + SQW'(prod);
        end
        gde_pkg::OP_SQRT_INIT: begin
          sv_r   <= sum_r;
          root_r <= '0;
          srem_r <= '0;
          scnt_r <= SCW'(DVW - 1);
        end
        gde_pkg::OP_SQRT_STEP: begin
          sv_r   <= sv_r << 2;
          srem_r <= s_ge ? (s_cat - s_trial) : s_cat;
          root_r <= {root_r[DVW-2:0], s_ge};
          scnt_r <= scnt_r - SCW'(1);
        end
        gde_pkg::OP_GATE: accept_r <= gate_ok;
        gde_pkg::OP_DIV_INIT: begin
          drem_r <= div_num[DVW+QW-1:QW];
          dnum_r <= div_num[QW-1:0];
          dd_r   <= root_r;
          dq_r   <= '0;
          dcnt_r <= DCW'(QW - 1);
          dneg_r <= cmd.phase ? b_neg_r[cmd.idx] : (a_neg_r[cmd.idx] ^ flip_r);
        end
        gde_pkg::OP_DIV_STEP: begin
          drem_r <= d_ge ? DVW'(r_cat - {1'b0, dd_r}) : DVW'(r_cat);
          dnum_r <= dnum_r << 1;
          dq_r   <= {dq_r[QW-2:0], d_ge};
          dcnt_r <= dcnt_r - DCW'(1);
        end
        gde_pkg::OP_DIV_STORE: begin
          if (cmd.phase) up_r[cmd.idx] <= q_signed;
          else           u_r[cmd.idx]  <= q_signed;
        end
        gde_pkg::OP_SEED: begin
          for (int i = 0; i < 3; i++) up_r[i] <= u_r[i];
          seeded_r <= 1'b1;
        end
        gde_pkg::OP_BLEND_A: begin
          pa_r     <= PW'(prod);
          pa_neg_r <= u_r[cmd.idx][UW-1];
        end
        gde_pkg::OP_BLEND_B: begin
          pb_r     <= PW'(prod);
          pb_neg_r <= up_r[cmd.idx][UW-1];
        end
        gde_pkg::OP_BLEND_C: begin
          b_mag_r[cmd.idx] <= bl_rnd[BMW-1:0];
          b_neg_r[cmd.idx] <= bl_sum[SW-1];
        end
        gde_pkg::OP_FINISH: begin
          acc_cnt_r   <= acc_cnt_nxt;
          rej_cnt_r   <= rej_cnt_nxt;
          out_user_r  <= {accept_r, ready_nxt};
          out_data_r  <= {rej_cnt_nxt,
                          ready_nxt ? 16'(up_r[2]) : 16'h0000,
                          ready_nxt ? 16'(up_r[1]) : 16'h0000,
                          ready_nxt ? 16'(up_r[0]) : 16'h0000};
        end
        default: ;
      endcase
    end
  end

  assign sts.sqrt_last = (scnt_r == '0);
  assign sts.div_last  = (dcnt_r == '0);
  assign sts.accept    = accept_r;
  assign sts.seeded    = seeded_r;
  assign sts.root_zero = (root_r == '0);
  assign sts.out_valid = out_valid_r;

  assign out_data = out_data_r;
  assign out_user = out_user_r;

endmodule

### design/gde_ctrl.sv
// ----------------------------------------------------------------------------
// gde_ctrl
// Sequencer: magnitude, gate, normalize, seed or blend, renormalize, output.
// ----------------------------------------------------------------------------
module gde_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_ready,
  input  gde_pkg::dp_sts_t sts,
  output gde_pkg::dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_SQRT_INIT,
    S_SQRT_RUN,
    S_GATE,
    S_GATE_CHK,
    S_DIV_INIT,
    S_DIV_RUN,
    S_DIV_STORE,
    S_SEED,
    S_BLA,
    S_BLB,
    S_BLC,
    S_MCHK,
    S_FINISH
  } state_t;

  state_t     state_r;
  logic [1:0] idx_r;
  logic       phase_r;

  assign in_ready  = (state_r == S_IDLE);
  assign cmd.idx   = idx_r;
  assign cmd.phase = phase_r;

  always_comb begin
    case (state_r)
      S_IDLE:      cmd.op = in_valid ? gde_pkg::OP_LOAD : gde_pkg::OP_NOP;
      S_SQ:        cmd.op = gde_pkg::OP_SQ;
      S_SQRT_INIT: cmd.op = gde_pkg::OP_SQRT_INIT;
      S_SQRT_RUN:  cmd.op = gde_pkg::OP_SQRT_STEP;
      S_GATE:      cmd.op = gde_pkg::OP_GATE;
      S_DIV_INIT:  cmd.op = gde_pkg::OP_DIV_INIT;
      S_DIV_RUN:   cmd.op = gde_pkg::OP_DIV_STEP;
      S_DIV_STORE: cmd.op = gde_pkg::OP_DIV_STORE;
      S_SEED:      cmd.op = gde_pkg::OP_SEED;
      S_BLA:       cmd.op = gde_pkg::OP_BLEND_A;
      S_BLB:       cmd.op = gde_pkg::OP_BLEND_B;
      S_BLC:       cmd.op = gde_pkg::OP_BLEND_C;
      S_FINISH:    cmd.op = (!sts.out_valid || out_ready) ? gde_pkg::OP_FINISH
                                                          : gde_pkg::OP_NOP;
      default:     cmd.op = gde_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= 2'd0;
      phase_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_SQ;
            idx_r   <= 2'd0;
            phase_r <= 1'b0;
          end
        end
        S_SQ: begin
          if (idx_r == 2'd2) state_r <= S_SQRT_INIT;
          else idx_r <= idx_r + 2'd1;
        end
        S_SQRT_INIT: state_r <= S_SQRT_RUN;
        S_SQRT_RUN: begin
          if (sts.sqrt_last) state_r <= phase_r ? S_MCHK : S_GATE;
        end
        S_GATE: state_r <= S_GATE_CHK;
        S_GATE_CHK: begin
          idx_r   <= 2'd0;
          state_r <= sts.accept ? S_DIV_INIT : S_FINISH;
        end
        S_DIV_INIT: state_r <= S_DIV_RUN;
        S_DIV_RUN: begin
          if (sts.div_last) state_r <= S_DIV_STORE;
        end
        S_DIV_STORE: begin
          if (idx_r != 2'd2) begin
            idx_r   <= idx_r + 2'd1;
            state_r <= S_DIV_INIT;
          end else if (phase_r) begin
            state_r <= S_FINISH;
          end else if (sts.seeded) begin
            idx_r   <= 2'd0;
            phase_r <= 1'b1;
            state_r <= S_BLA;
          end else begin
            state_r <= S_SEED;
          end
        end
        S_SEED: state_r <= S_FINISH;
        S_BLA:  state_r <= S_BLB;
        S_BLB:  state_r <= S_BLC;
        S_BLC: begin
          if (idx_r == 2'd2) begin
            idx_r   <= 2'd0;
            state_r <= S_SQ;
          end else begin
            idx_r   <= idx_r + 2'd1;
            state_r <= S_BLA;
          end
        end
        // zero blend keeps the stored vector
        S_MCHK: begin
          idx_r   <= 2'd0;
          state_r <= sts.root_zero ? S_FINISH : S_DIV_INIT;
        end
        S_FINISH: begin
          if (!sts.out_valid || out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### design/gravity_direction_estimator.sv
// ----------------------------------------------------------------------------
// gravity_direction_estimator
// Low-pass estimate of the up unit vector from three-axis accelerometer items.
// ----------------------------------------------------------------------------
// channel  dir  handshake           payload
// in_      in   in_tvalid/tready    tdata: accel_x, accel_y, accel_z
// out_     out  out_tvalid/tready   tdata: up x/y/z, rejected_total;
//                                   tuser: ready_res, sample_accepted
// cfg_     in   cfg_we              cfg_index, cfg_wdata
//
// One item at a time. A rejected item runs the squares, the bit-serial square root
// and the gate; an accepted one adds three serial divides, then seeds, or blends,
// takes a second root and, unless the blend is zero, renormalizes with three more
// divides. DVW = max(ACCEL_WIDTH, F+17-shift) is the width of the square root (one
// root bit per cycle). Synchronous active-low reset; no clearing pass. The next item
// is taken while a result waits in the output register; a stalled result stalls the
// following item only at its output step.
module gravity_direction_estimator #(
  parameter int ACCEL_WIDTH    = 16,
  parameter int UNIT_FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // accel_x, accel_y, accel_z (ACCEL_WIDTH each), zero padded to bytes
  input  logic [((3*ACCEL_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // up_out_x[15:0], up_out_y[31:16], up_out_z[47:32], rejected_total[63:48]
  output logic [gde_pkg::OUT_DATA_W-1:0]    out_tdata,
  // ready_res[0], sample_accepted[1]
  output logic [gde_pkg::OUT_USER_W-1:0]    out_tuser,
  input  logic                              cfg_we,
  input  logic [gde_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gde_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int IN_W = ((3*ACCEL_WIDTH+7)/8)*8;

  gde_pkg::dp_cmd_t cmd;
  gde_pkg::dp_sts_t sts;

  gde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gde_datapath #(
    .ACCEL_WIDTH    (ACCEL_WIDTH),
    .UNIT_FRAC_BITS (UNIT_FRAC_BITS),
    .IN_W           (IN_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_tdata),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_user  (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  assign out_tvalid = sts.out_valid;

endmodule

### design/gde_checker.sv
// ----------------------------------------------------------------------------
// gde_checker
// Port-level checks on the gravity direction estimator.
// ----------------------------------------------------------------------------
module gde_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [gde_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [gde_pkg::OUT_USER_W-1:0] out_tuser
);

  logic [15:0] last_rej_r;

  always_ff @(posedge clk) begin
    if (!rst_n) last_rej_r <= '0;
    else if (out_tvalid && out_tready) last_rej_r <= out_tdata[63:48];
  end

  // one item in flight: no new item right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item taken while another is in flight");

  // estimate is zero until ready
  a_zero_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[47:0] == 48'h0))
    else $error("up vector shown while not ready");

  // saturating reject count never goes down
  a_rej_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[63:48] >= last_rej_r))
    else $error("rejected count decreased");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind gravity_direction_estimator gde_checker u_gde_checker (.*);

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives accelerometer items into the gravity direction estimator, predicts
// the up vector, the magnitude gate and the counters per item, and checks
// every result in order.
// ----------------------------------------------------------------------------
class up_scoreboard;
  logic [63:0] pend_data[$];
  logic [1:0]  pend_user[$];
  int          errors = 0;

  function void note(logic [63:0] d, logic [1:0] u);
    pend_data.push_back(d);
    pend_user.push_back(u);
  endfunction

  function void check(logic [63:0] d, logic [1:0] u);
    logic [63:0] ed;
    logic [1:0]  eu;
    if (pend_data.size() == 0) begin
      $error("result with nothing pending: data %h user %h", d, u);
      errors++;
      return;
    end
    ed = pend_data.pop_front();
    eu = pend_user.pop_front();
    if (eu[0] !== u[0]) begin
      $error("ready_res expected %0d got %0d", eu[0], u[0]); errors++;
    end
    if (eu[1] !== u[1]) begin
      $error("sample_accepted expected %0d got %0d", eu[1], u[1]); errors++;
    end
    if (ed[15:0] !== d[15:0]) begin
      $error("up_out_x expected %0d got %0d", $signed(ed[15:0]), $signed(d[15:0])); errors++;
    end
    if (ed[31:16] !== d[31:16]) begin
      $error("up_out_y expected %0d got %0d", $signed(ed[31:16]), $signed(d[31:16]));
      errors++;
    end
    if (ed[47:32] !== d[47:32]) begin
      $error("up_out_z expected %0d got %0d", $signed(ed[47:32]), $signed(d[47:32]));
      errors++;
    end
    if (ed[63:48] !== d[63:48]) begin
      $error("rejected_total expected %0d got %0d", ed[63:48], d[63:48]); errors++;
    end
  endfunction
endclass

module testbench;

  localparam longint GRAV = 10042;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we = 0;
  logic [gde_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gde_pkg::CFG_W-1:0]     cfg_wdata = '0;

  gravity_direction_estimator DUT (.*);

  initial forever #10 clk = ~clk;

  up_scoreboard sb = new();
  longint cycles = 0;
  bit     in_done = 0;
  int     out_wait = 0;

  // predictor state
  longint alpha_q = 6554, warmup_q = 10, tol_q = 9830, flip_q = 0;
  longint upv[3];
  bit     seeded = 0;
  longint acc_cnt = 0, rej_cnt = 0;

  function automatic longint isqrt(longint v);
    longint r = 0, b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else r = r >>> 1;
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint unit_div(longint v, longint d);
    longint m = (v < 0) ? -v : v;
    longint q = ((m <<< 14) + d / 2) / d;
    return (v < 0) ? -q : q;
  endfunction

  task automatic predict_gate(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az);
    longint a[3], u[3], b[3], n, dev, m, al;
    bit ok, rdy;
    a[0] = ax; a[1] = ay; a[2] = az;
    n = isqrt(a[0]*a[0] + a[1]*a[1] + a[2]*a[2]);
    ok = 0;
    if (n != 0) begin
      dev = (n > GRAV) ? n - GRAV : GRAV - n;
      ok = (dev <<< 16) <= tol_q * GRAV;
    end
    if (!ok) begin
      if (rej_cnt < 65535) rej_cnt++;
    end else begin
      for (int i = 0; i < 3; i++) begin
        u[i] = unit_div(a[i], n);
        if (flip_q != 0) u[i] = -u[i];
      end
      if (!seeded) begin
        upv = u;
        seeded = 1;
      end else begin
        al = (alpha_q > 65536) ? 65536 : alpha_q;
        for (int i = 0; i < 3; i++) b[i] = al * u[i] + (65536 - al) * upv[i];
        m = isqrt(b[0]*b[0] + b[1]*b[1] + b[2]*b[2]);
        if (m != 0) for (int i = 0; i < 3; i++) upv[i] = unit_div(b[i], m);
      end
      if (acc_cnt < 65535) acc_cnt++;
    end
    rdy = seeded && acc_cnt >= warmup_q;
    sb.note({rej_cnt[15:0], rdy ? upv[2][15:0] : 16'h0, rdy ? upv[1][15:0] : 16'h0,
             rdy ? upv[0][15:0] : 16'h0}, {ok, rdy});
  endtask

  // valid stays up after an accept until the next gap or a drain
  task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    int gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_gate(x, y, z);
  endtask

  task automatic write_reg(logic [gde_pkg::CFG_IDX_W-1:0] idx, longint val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_wdata <= val[16:0];
    @(posedge clk);
    cfg_we    <= 0;
    @(posedge clk);
    case (idx)
      gde_pkg::REG_BLEND_ALPHA: alpha_q  = val & 17'h1FFFF;
      gde_pkg::REG_WARMUP:      warmup_q = val & 16'hFFFF;
      gde_pkg::REG_MAG_TOL:     tol_q    = val & 16'hFFFF;
      gde_pkg::REG_FLIP:        flip_q   = val & 1;
      default: ;
    endcase
  endtask

  task automatic drain;
    in_tvalid <= 0;
    while (sb.pend_data.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // sample near 1 g with random direction, scaled by s/1024
  task automatic send_near_g(int s);
    longint v[3], n;
    v[0] = $signed(16'($urandom)) ; v[1] = $signed(16'($urandom));
    v[2] = $signed(16'($urandom));
    n = isqrt(v[0]*v[0] + v[1]*v[1] + v[2]*v[2]);
    if (n == 0) begin v[2] = 1000; n = 1000; end
    for (int i = 0; i < 3; i++) v[i] = v[i] * GRAV * s / 1024 / n;
    send_sample(v[0][15:0], v[1][15:0], v[2][15:0]);
  endtask

  // output side: ready is held low for a random wait after each taken item
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        sb.check(out_tdata, out_tuser);
        out_wait = $urandom_range(0, 5);
      end else if (out_tvalid && out_wait > 0) begin
        out_wait = out_wait - 1;
      end
      out_tready <= (out_wait == 0);
    end
  end

  initial begin
    upv = '{0, 0, 0};
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extremes, zero, exact g, each axis, saturating corners
    send_sample(16'h0, 16'h0, 16'h0);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'd10042, 16'h0, 16'h0);
    send_sample(16'h0, -16'sd10042, 16'h0);
    send_sample(16'h0, 16'h0, 16'd10042);
    send_sample(16'h0, 16'h0, -16'sd10042);
    send_sample(16'd5798, 16'd5798, 16'd5798);
    send_sample(16'd1, 16'd0, 16'd0);
    drain();
    write_reg(gde_pkg::REG_FLIP, 1);
    write_reg(gde_pkg::REG_BLEND_ALPHA, 65536);
    write_reg(gde_pkg::REG_WARMUP, 0);
    send_sample(16'd10042, 16'h0, 16'h0);
    send_sample(-16'sd10042, 16'h0, 16'h0);
    drain();
    write_reg(gde_pkg::REG_BLEND_ALPHA, 0);
    write_reg(gde_pkg::REG_MAG_TOL, 65535);
    send_sample(16'h0, 16'd10042, 16'h0);
    send_sample(16'h0, 16'h7FFF, 16'h0);
    drain();
    write_reg(gde_pkg::REG_BLEND_ALPHA, 131071);
    write_reg(gde_pkg::REG_MAG_TOL, 0);
    send_sample(16'd10042, 16'h0, 16'h0);
    send_sample(16'd10043, 16'h0, 16'h0);
    drain();
    write_reg(gde_pkg::REG_BLEND_ALPHA, 32768);
    write_reg(gde_pkg::REG_MAG_TOL, 9830);
    write_reg(gde_pkg::REG_WARMUP, 65535);
    write_reg(gde_pkg::REG_FLIP, 0);
    // opposite samples at half blend: cancels to a zero blend
    send_sample(16'd10042, 16'h0, 16'h0);
    send_sample(-16'sd10042, 16'h0, 16'h0);
    drain();
    // random phases
    for (int ph = 0; ph < 11; ph++) begin
      write_reg(gde_pkg::REG_BLEND_ALPHA, (ph % 4 == 0) ? $urandom_range(0, 131071)
                                                        : $urandom_range(0, 65536));
      write_reg(gde_pkg::REG_WARMUP, (ph == 3) ? 65535 : $urandom_range(0, 40));
      write_reg(gde_pkg::REG_MAG_TOL, (ph == 5) ? 0 : (ph == 6) ? 65535
                                                : $urandom_range(1000, 20000));
      write_reg(gde_pkg::REG_FLIP, $urandom_range(0, 1));
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 9) < 7) send_near_g($urandom_range(900, 1150));
        else send_sample(16'($urandom), 16'($urandom), 16'($urandom));
      end
      drain();
    end
    in_done = 1;
  end

  initial begin
    wait (in_done);
    if (sb.errors == 0 && sb.pend_data.size() == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  initial begin
    wait (cycles > 1500000);
    $display("testbench: done, errors");
    $finish;
  end
endmodule
